[hw/rtl/lar_pkg.sv]
// lar_pkg: shared types and constants for the lottery arbiter.
// Used by lar_ctrl, lar_dpath and lottery_arbiter_refill. No dependencies.
package lar_pkg;

    // Field widths
    localparam int OP_W       = 2;
    localparam int RND_W      = 16;
    localparam int PID_W      = 4;
    localparam int CNT_W      = 4;
    localparam int CNT_MAX    = 15;
    localparam int ACT_W      = 5;
    localparam int RPR_W      = 4;
    localparam int WIN_W      = 4;
    localparam int TOT_OUT_W  = 8;
    localparam int ENT_W      = 8;

    // Word layouts
    localparam int S_DATA_W   = 24;
    localparam int M_DATA_W   = 24;
    localparam int OP_LSB     = 0;
    localparam int RND_LSB    = 2;
    localparam int PID_LSB    = 18;
    localparam int WIN_LSB    = 0;
    localparam int TOT_LSB    = 4;
    localparam int ENT_LSB    = 12;

    // Config port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REFILL = 2'd1;
    localparam logic [ACT_W-1:0]     ACT_RESET  = 5'd1;
    localparam logic [RPR_W-1:0]     RPR_RESET  = 4'd5;

    // Operation codes
    localparam logic [OP_W-1:0] OP_INIT   = 2'd0;
    localparam logic [OP_W-1:0] OP_DRAW   = 2'd1;
    localparam logic [OP_W-1:0] OP_RETIRE = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUM,
        ST_DIV,
        ST_FIND,
        ST_UPDATE,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic accept;    // input word taken this cycle
        logic walk_en;   // step the count walk
        logic find;      // walk looks for the drawn entry
        logic sum_end;   // latch total, restart walk, start divide
        logic div_step;  // one remainder bit
        logic update;    // write back winner count
        logic load_out;  // move result into output register
    } cmd_t;

    typedef struct packed {
        logic in_draw;
        logic walk_done;
        logic total_zero;
        logic div_done;
        logic found;
        logic out_free;
    } status_t;

endpackage

[hw/rtl/lar_ctrl.sv]
// lar_ctrl: sequencer for the lottery arbiter.
// Depends on lar_pkg (state_t, cmd_t, status_t).
module lar_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  lar_pkg::status_t st,
    output lar_pkg::cmd_t    cmd
);

    lar_pkg::state_t state_reg;
    lar_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lar_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            lar_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.accept = 1'b1;
                    state_next = st.in_draw ? lar_pkg::ST_SUM : lar_pkg::ST_DONE;
                end
            end
            lar_pkg::ST_SUM:
            begin
                cmd.walk_en = 1'b1;
                if (st.walk_done)
                begin
                    cmd.sum_end = 1'b1;
                    state_next  = st.total_zero ? lar_pkg::ST_DONE : lar_pkg::ST_DIV;
                end
            end
            lar_pkg::ST_DIV:
            begin
                if (st.div_done)
                begin
                    state_next = lar_pkg::ST_FIND;
                end
                else
                begin
                    cmd.div_step = 1'b1;
                end
            end
            lar_pkg::ST_FIND:
            begin
                cmd.walk_en = 1'b1;
                cmd.find    = 1'b1;
                if (st.found)
                begin
                    state_next = lar_pkg::ST_UPDATE;
                end
            end
            lar_pkg::ST_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = lar_pkg::ST_DONE;
            end
            lar_pkg::ST_DONE:
            begin
                if (st.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = lar_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lar_pkg::ST_IDLE;
            end
        endcase
    end

    // Result only loaded into a free output slot
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> st.out_free)
        else $error("result loaded over a pending word");

    // Non-draw words skip straight to the result
    a_nondraw_done: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.accept && !st.in_draw) |=> (state_reg == lar_pkg::ST_DONE))
        else $error("non-draw word did not finish at once");

    // Search over a non-zero total always hits before the walk ends
    a_find_hits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == lar_pkg::ST_FIND && st.walk_done) |-> st.found)
        else $error("draw walk ended without a winner");

    // Write-back only for a located winner
    a_update_found: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == lar_pkg::ST_UPDATE) |-> st.found)
        else $error("update without winner");

endmodule

[hw/rtl/lar_dpath.sv]
// lar_dpath: ticket store, count walk, serial remainder and output register.
// Depends on lar_pkg (widths, codes, cmd_t, status_t).
module lar_dpath #(
    parameter int MAX_PROCS  = 16,
    parameter int REFILL_MAX = 15
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [lar_pkg::S_DATA_W-1:0]      s_tdata,
    input  logic                              cfg_valid,
    input  logic [lar_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [lar_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                              m_tready,
    input  lar_pkg::cmd_t                     cmd,
    output lar_pkg::status_t                  st,
    output logic                              m_tvalid,
    output logic [lar_pkg::M_DATA_W-1:0]      m_tdata,
    output logic                              m_tuser
);

    localparam int IDX_W  = $clog2(MAX_PROCS);
    localparam int N_W    = $clog2(MAX_PROCS + 1);
    localparam int TOT_W  = $clog2(MAX_PROCS * lar_pkg::CNT_MAX + 1);
    localparam int DIV_CW = $clog2(lar_pkg::RND_W + 1);

    // Input fields
    logic [lar_pkg::OP_W-1:0]  in_op;
    logic [lar_pkg::RND_W-1:0] in_rnd;
    logic [lar_pkg::PID_W-1:0] in_pid;

    assign in_op  = s_tdata[lar_pkg::OP_LSB  +: lar_pkg::OP_W];
    assign in_rnd = s_tdata[lar_pkg::RND_LSB +: lar_pkg::RND_W];
    assign in_pid = s_tdata[lar_pkg::PID_LSB +: lar_pkg::PID_W];

    // Config registers
    logic [lar_pkg::ACT_W-1:0] act_reg;
    logic [lar_pkg::RPR_W-1:0] rpr_reg;
    logic [N_W-1:0]            n_cur;
    logic [lar_pkg::CNT_W-1:0] r_cur;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_reg <= lar_pkg::ACT_RESET;
            rpr_reg <= lar_pkg::RPR_RESET;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == lar_pkg::REG_ACTIVE)
            begin
                act_reg <= cfg_data[lar_pkg::ACT_W-1:0];
            end
            else if (cfg_index == lar_pkg::REG_REFILL)
            begin
                rpr_reg <= cfg_data[lar_pkg::RPR_W-1:0];
            end
        end
    end

    // Saturated active count and refill size
    always_comb
    begin
        if (32'(act_reg) > MAX_PROCS)
        begin
            n_cur = N_W'(MAX_PROCS);
        end
        else
        begin
            n_cur = N_W'(act_reg);
        end
        if (32'(rpr_reg) > REFILL_MAX)
        begin
            r_cur = lar_pkg::CNT_W'(REFILL_MAX);
        end
        else
        begin
            r_cur = lar_pkg::CNT_W'(rpr_reg);
        end
    end

    // Ticket store. An entry without its valid bit reads from the last init:
    // init_r below init_n, zero from init_n up.
    logic [lar_pkg::CNT_W-1:0] mem [MAX_PROCS];
    logic [MAX_PROCS-1:0]      vld_reg;
    logic [N_W-1:0]            init_n_reg;
    logic [lar_pkg::CNT_W-1:0] init_r_reg;

    logic [N_W-1:0]            idx_reg;
    logic                      rdv_reg;
    logic                      found_reg;
    logic [TOT_W-1:0]          acc_reg;
    logic [TOT_W-1:0]          acc_sum;
    logic [lar_pkg::CNT_W-1:0] rd_data_reg;
    logic                      rd_vldb_reg;
    logic [IDX_W-1:0]          rd_addr_reg;
    logic [lar_pkg::CNT_W-1:0] cnt_eff;
    logic                      issue;
    logic                      hit;

    logic [IDX_W-1:0]          win_idx_reg;
    logic [lar_pkg::CNT_W-1:0] win_cnt_reg;
    logic [lar_pkg::CNT_W-1:0] win_dec;

    logic                      wr_en;
    logic [IDX_W-1:0]          wr_addr;
    logic [lar_pkg::CNT_W-1:0] wr_data;
    logic                      do_retire;
    logic                      do_init;

    // Divider
    logic [TOT_W-1:0]          total_reg;
    logic [TOT_W-1:0]          rem_reg;
    logic [lar_pkg::RND_W-1:0] dvd_reg;
    logic [DIV_CW-1:0]         div_cnt_reg;
    logic [TOT_W:0]            div_try;

    logic                         m_tvalid_reg;
    logic [lar_pkg::M_DATA_W-1:0] res_word;

    assign issue = cmd.walk_en && (idx_reg < n_cur);

    always_comb
    begin
        if (rd_vldb_reg)
        begin
            cnt_eff = rd_data_reg;
        end
        else if (N_W'(rd_addr_reg) < init_n_reg)
        begin
            cnt_eff = init_r_reg;
        end
        else
        begin
            cnt_eff = '0;
        end
    end

    assign acc_sum = acc_reg + TOT_W'(cnt_eff);
    assign hit     = cmd.find && rdv_reg && !found_reg && (rem_reg < acc_sum);

    // Walk control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            rdv_reg   <= 1'b0;
            found_reg <= 1'b0;
            acc_reg   <= '0;
        end
        else if (cmd.accept || cmd.sum_end)
        begin
            idx_reg   <= '0;
            rdv_reg   <= 1'b0;
            found_reg <= 1'b0;
            acc_reg   <= '0;
        end
        else
        begin
            if (issue)
            begin
                idx_reg <= idx_reg + N_W'(1);
            end
            rdv_reg <= issue;
            if (rdv_reg)
            begin
                acc_reg <= acc_sum;
            end
            if (hit)
            begin
                found_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (hit)
        begin
            win_idx_reg <= rd_addr_reg;
            win_cnt_reg <= cnt_eff;
        end
    end

    // Store write: retire at accept, winner write-back at update
    assign do_init   = cmd.accept && (in_op == lar_pkg::OP_INIT);
    assign do_retire = cmd.accept && (in_op == lar_pkg::OP_RETIRE)
                       && (32'(in_pid) < MAX_PROCS);
    assign win_dec   = win_cnt_reg - lar_pkg::CNT_W'(1);

    always_comb
    begin
        wr_en = do_retire || cmd.update;
        if (cmd.update)
        begin
            wr_addr = win_idx_reg;
            wr_data = (win_dec == '0) ? r_cur : win_dec;
        end
        else
        begin
            wr_addr = IDX_W'(in_pid);
            wr_data = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (issue)
        begin
            rd_data_reg <= mem[idx_reg[IDX_W-1:0]];
            rd_vldb_reg <= vld_reg[idx_reg[IDX_W-1:0]];
            rd_addr_reg <= idx_reg[IDX_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            init_n_reg <= '0;
            init_r_reg <= '0;
        end
        else if (do_init)
        begin
            vld_reg    <= '0;
            init_n_reg <= n_cur;
            init_r_reg <= r_cur;
        end
        else if (wr_en)
        begin
            vld_reg[wr_addr] <= 1'b1;
        end
    end

    // Restoring remainder, one dividend bit a cycle
    assign div_try = {rem_reg, dvd_reg[lar_pkg::RND_W-1]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_cnt_reg <= '0;
            total_reg   <= '0;
            rem_reg     <= '0;
            dvd_reg     <= '0;
        end
        else if (cmd.accept)
        begin
            dvd_reg <= in_rnd;
        end
        else if (cmd.sum_end)
        begin
            total_reg   <= acc_reg;
            rem_reg     <= '0;
            div_cnt_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            if (div_try >= {1'b0, total_reg})
            begin
                rem_reg <= TOT_W'(div_try - {1'b0, total_reg});
            end
            else
            begin
                rem_reg <= TOT_W'(div_try);
            end
            dvd_reg     <= {dvd_reg[lar_pkg::RND_W-2:0], 1'b0};
            div_cnt_reg <= div_cnt_reg + DIV_CW'(1);
        end
    end

    // Output register; all fields zero unless a winner was found
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_comb
    begin
        res_word = '0;
        if (found_reg)
        begin
            res_word[lar_pkg::WIN_LSB +: lar_pkg::WIN_W]     = lar_pkg::WIN_W'(win_idx_reg);
            res_word[lar_pkg::TOT_LSB +: lar_pkg::TOT_OUT_W] = lar_pkg::TOT_OUT_W'(total_reg);
            res_word[lar_pkg::ENT_LSB +: lar_pkg::ENT_W]     = lar_pkg::ENT_W'(rem_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            m_tuser <= found_reg;
            m_tdata <= res_word;
        end
    end

    assign m_tvalid = m_tvalid_reg;

    always_comb
    begin
        st.in_draw    = (in_op == lar_pkg::OP_DRAW);
        st.walk_done  = (idx_reg == n_cur) && !rdv_reg;
        st.total_zero = (acc_reg == '0);
        st.div_done   = (div_cnt_reg == DIV_CW'(lar_pkg::RND_W));
        st.found      = found_reg;
        st.out_free   = !m_tvalid_reg || m_tready;
    end

endmodule

[hw/rtl/lottery_arbiter_refill.sv]
// lottery_arbiter_refill: lottery arbiter top level.
// Instantiates lar_ctrl and lar_dpath; depends on lar_pkg.
// Usage
//   s_* channel: one command word per handshake (init, draw or retire).
//   m_* channel: exactly one result word per command word, in order.
//   cfg_* channel: register writes (index 0 active count, 1 refill size),
//   always ready; write only while no command is in flight.
// Sequence
//   Init, retire and the unused code go straight to the result.
//   A draw sums the counts, runs a serial remainder over the 16-bit random
//   value, then searches at one store read per cycle for the winner; it
//   skips the remainder and the search when no tickets remain. One command
//   at a time: s_tready is high only when the sequencer is idle, from the
//   cycle after the result is loaded.
// Reset
//   All ticket counts read as zero, active count 1, refill size 5.
// Stall
//   A finished result sits in the output register while m_tready is low and
//   the next command is still taken; that command's result waits until the
//   register frees.
module lottery_arbiter_refill #(
    parameter int MAX_PROCS  = 16,
    parameter int REFILL_MAX = 15
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    // command word
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [1:0] operation, [17:2] random_value, [21:18] process_id, [23:22] zero
    input  logic [lar_pkg::S_DATA_W-1:0]   s_tdata,
    // result word
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [3:0] winner, [11:4] total_tickets, [19:12] drawn_entry, [23:20] zero
    output logic [lar_pkg::M_DATA_W-1:0]   m_tdata,
    // [0] has_winner
    output logic                           m_tuser,
    // register writes
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [lar_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lar_pkg::CFG_DATA_W-1:0] cfg_data
);

    lar_pkg::cmd_t    cmd;
    lar_pkg::status_t st;

    // register file never stalls
    assign cfg_ready = 1'b1;

    lar_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    lar_dpath #(
        .MAX_PROCS  (MAX_PROCS),
        .REFILL_MAX (REFILL_MAX)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tready  (m_tready),
        .cmd       (cmd),
        .st        (st),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule
